// ===== rtl/tlpw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlpw_pkg;

	localparam int VA_BITS    = 16;
	localparam int PA_BITS    = 14;
	localparam int PAGE_BITS  = 8;
	localparam int PN_BITS    = VA_BITS - PAGE_BITS;
	localparam int L1_BITS    = PN_BITS / 2;
	localparam int L2_BITS    = PN_BITS - L1_BITS;
	localparam int FRAME_BITS = PA_BITS - PAGE_BITS;
	localparam int NUM_L1     = 1 << L1_BITS;
	localparam int NUM_PAGES  = 1 << PN_BITS;
	localparam int NUM_FRAMES = 1 << FRAME_BITS;
	localparam int STATUS_BITS = 2;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_HIT  = 2'd0,
		ST_NEW  = 2'd1,
		ST_FULL = 2'd2
	} walk_status_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} walk_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/tlpw_va_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tlpw_va_if;
	logic                          valid;
	logic                          ready;
	logic [tlpw_pkg::VA_BITS-1:0]  virtual_address;

	modport source (output valid, output virtual_address, input ready);
	modport sink (input valid, input virtual_address, output ready);
endinterface

`default_nettype wire

// ===== rtl/tlpw_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tlpw_res_if;
	logic                              valid;
	logic                              ready;
	logic [tlpw_pkg::PA_BITS-1:0]      physical_address;
	logic [tlpw_pkg::FRAME_BITS-1:0]   frame_index;
	logic [tlpw_pkg::STATUS_BITS-1:0]  status;
	logic                              new_second_level;

	modport source (
		output valid, output physical_address, output frame_index,
		output status, output new_second_level, input ready
	);
	modport sink (
		input valid, input physical_address, input frame_index,
		input status, input new_second_level, output ready
	);
endinterface

`default_nettype wire

// ===== rtl/tlpw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlpw_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output tlpw_pkg::walk_cmd_t     cmd
);

	typedef enum logic {
		IDLE,
		LOOKUP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free    = !out_valid_q || rsp_ready;
	assign req_ready   = (state_q == IDLE);
	assign rsp_valid   = out_valid_q;
	assign cmd.capture = req_valid && (state_q == IDLE);
	assign cmd.commit  = (state_q == LOOKUP) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (req_valid) begin
						state_q <= LOOKUP;
					end
				end
				LOOKUP: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tlpw_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlpw_dpath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire tlpw_pkg::walk_cmd_t                  cmd,
	input  wire logic [tlpw_pkg::VA_BITS-1:0]         virtual_address,
	output logic [tlpw_pkg::PA_BITS-1:0]              physical_address,
	output logic [tlpw_pkg::FRAME_BITS-1:0]           frame_index,
	output logic [tlpw_pkg::STATUS_BITS-1:0]          status,
	output logic                                      new_second_level
);

	localparam int PAGE_BITS  = tlpw_pkg::PAGE_BITS;
	localparam int PN_BITS    = tlpw_pkg::PN_BITS;
	localparam int L1_BITS    = tlpw_pkg::L1_BITS;
	localparam int L2_BITS    = tlpw_pkg::L2_BITS;
	localparam int FRAME_BITS = tlpw_pkg::FRAME_BITS;
	localparam int PA_BITS    = tlpw_pkg::PA_BITS;

	logic [FRAME_BITS-1:0]          frame_mem [tlpw_pkg::NUM_PAGES];
	logic [tlpw_pkg::NUM_PAGES-1:0] entry_valid_q;
	logic [tlpw_pkg::NUM_L1-1:0]    l1_present_q;
	logic [FRAME_BITS:0]            fill_q;

	logic [PN_BITS-1:0]             page_q;
	logic [PAGE_BITS-1:0]           offset_q;
	logic [FRAME_BITS-1:0]          frame_rd_q;
	logic                           entry_hit_q;

	logic [PN_BITS-1:0]             req_page;
	logic [L1_BITS-1:0]             l1_idx;
	logic                           mem_full;
	logic                           alloc;
	logic [FRAME_BITS-1:0]          frame_sel;
	logic [1:0]                     status_sel;

	logic [PA_BITS-1:0]             pa_q;
	logic [FRAME_BITS-1:0]          frame_q;
	logic [1:0]                     status_q;
	logic                           new_l2_q;

	assign req_page   = virtual_address[PAGE_BITS +: PN_BITS];
	assign l1_idx     = page_q[L2_BITS +: L1_BITS];
	// Frames are never released, so the lowest free frame is the fill count.
	assign mem_full   = fill_q[FRAME_BITS];
	assign alloc      = !entry_hit_q && !mem_full;

	always_comb begin
		if (entry_hit_q) begin
			frame_sel  = frame_rd_q;
			status_sel = tlpw_pkg::ST_HIT;
		end else if (mem_full) begin
			frame_sel  = '0;
			status_sel = tlpw_pkg::ST_FULL;
		end else begin
			frame_sel  = fill_q[FRAME_BITS-1:0];
			status_sel = tlpw_pkg::ST_NEW;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && alloc) begin
			frame_mem[page_q] <= fill_q[FRAME_BITS-1:0];
		end
		if (cmd.capture) begin
			frame_rd_q  <= frame_mem[req_page];
			entry_hit_q <= entry_valid_q[req_page];
			page_q      <= req_page;
			offset_q    <= virtual_address[PAGE_BITS-1:0];
		end
		if (cmd.commit) begin
			frame_q  <= frame_sel;
			status_q <= status_sel;
			new_l2_q <= !l1_present_q[l1_idx];
			if (mem_full && !entry_hit_q) begin
				pa_q <= '0;
			end else begin
				pa_q <= {frame_sel, offset_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			l1_present_q  <= '0;
			fill_q        <= '0;
		end else if (cmd.commit) begin
			l1_present_q[l1_idx] <= 1'b1;
			if (alloc) begin
				entry_valid_q[page_q] <= 1'b1;
				fill_q                <= fill_q + 1'b1;
			end
		end
	end

	assign physical_address = pa_q;
	assign frame_index      = frame_q;
	assign status           = status_q;
	assign new_second_level = new_l2_q;

endmodule

`default_nettype wire

// ===== rtl/two_level_page_walk_demand_alloc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Modport  Payload
// req      sink     virtual_address (16)
// rsp      source   physical_address (14), frame_index (6), status (2),
//                   new_second_level (1)
//
// For each address, the transfer cycle reads the page table memory, and the
// LOOKUP state then updates the tables and loads the result register.
// The result register holds a finished walk while the next address is taken;
// a walk waits in LOOKUP only while that register is full and rsp.ready is low.
// Reset clears all table valid bits and the frame fill count at once.

module two_level_page_walk_demand_alloc_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tlpw_va_if.sink    req,
	tlpw_res_if.source rsp
);

	tlpw_pkg::walk_cmd_t cmd;

	tlpw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	tlpw_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.virtual_address  (req.virtual_address),
		.physical_address (rsp.physical_address),
		.frame_index      (rsp.frame_index),
		.status           (rsp.status),
		.new_second_level (rsp.new_second_level)
	);

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int VA_BITS    = tlpw_pkg::VA_BITS;
	localparam int PA_BITS    = tlpw_pkg::PA_BITS;
	localparam int PAGE_BITS  = tlpw_pkg::PAGE_BITS;
	localparam int PN_BITS    = tlpw_pkg::PN_BITS;
	localparam int L1_BITS    = tlpw_pkg::L1_BITS;
	localparam int L2_BITS    = tlpw_pkg::L2_BITS;
	localparam int FRAME_BITS = tlpw_pkg::FRAME_BITS;
	localparam int NUM_L1     = tlpw_pkg::NUM_L1;
	localparam int NUM_PAGES  = tlpw_pkg::NUM_PAGES;
	localparam int NUM_FRAMES = tlpw_pkg::NUM_FRAMES;

	localparam int WALK_COUNT = 400;
	localparam int TAIL_ITEMS = 40;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [VA_BITS-1:0] va;
		bit                 hold;
	} va_item_t;

	typedef struct packed {
		logic [PA_BITS-1:0]     pa;
		logic [FRAME_BITS-1:0]  frame;
		tlpw_pkg::walk_status_t status;
		logic                   new_l2;
	} walk_result_t;

	localparam logic [VA_BITS-1:0] DIRECTED_VA [14] = '{
		16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h1234, 16'h1299, 16'h10AB,
		16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'h0080, 16'h1200, 16'hAA55
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tlpw_va_if  req();
	tlpw_res_if rsp();

	two_level_page_walk_demand_alloc_core DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	va_item_t     addr_queue[$];
	walk_result_t expected_walks[$];

	bit                    l1_present [NUM_L1];
	bit                    page_mapped [NUM_PAGES];
	logic [FRAME_BITS-1:0] page_frame [NUM_PAGES];
	bit                    frame_taken [NUM_FRAMES];

	int mismatch_count = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int stall_gap = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void predict_walk(input logic [VA_BITS-1:0] va);
		logic [PN_BITS-1:0] page;
		logic [L1_BITS-1:0] l1;
		walk_result_t       w;
		int                 free_frame;
		page = va[VA_BITS-1:PAGE_BITS];
		l1 = page[PN_BITS-1:L2_BITS];
		w.pa = '0;
		w.frame = '0;
		w.status = tlpw_pkg::ST_HIT;
		w.new_l2 = !l1_present[l1];
		l1_present[l1] = 1'b1;
		if (!page_mapped[page]) begin
			free_frame = -1;
			for (int f = 0; f < NUM_FRAMES && free_frame < 0; f++) begin
				if (!frame_taken[f])
					free_frame = f;
			end
			if (free_frame < 0) begin
				w.status = tlpw_pkg::ST_FULL;
			end else begin
				frame_taken[free_frame] = 1'b1;
				page_mapped[page] = 1'b1;
				page_frame[page] = FRAME_BITS'(free_frame);
				w.status = tlpw_pkg::ST_NEW;
			end
		end
		if (w.status != tlpw_pkg::ST_FULL) begin
			w.frame = page_frame[page];
			w.pa = PA_BITS'({w.frame, va[PAGE_BITS-1:0]});
		end
		expected_walks.push_back(w);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		va_item_t next_item;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.virtual_address <= '0;
			send_gap = 0;
		end else begin
			if (req.valid && req.ready)
				predict_walk(req.virtual_address);
			if (!req.valid || req.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req.valid <= 1'b0;
				end else if (addr_queue.size() == 0
						|| (addr_queue[0].hold && expected_walks.size() != 0)) begin
					req.valid <= 1'b0;
				end else if (addr_queue.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 11);
					req.valid <= 1'b0;
				end else begin
					next_item = addr_queue.pop_front();
					req.valid <= 1'b1;
					req.virtual_address <= next_item.va;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		walk_result_t w;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_gap = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_walks.size() == 0) begin
					$error("Result transfer with no walk pending: pa %0h frame %0d status %0d",
						rsp.physical_address, rsp.frame_index, rsp.status);
					mismatch_count++;
				end else begin
					w = expected_walks.pop_front();
					if (rsp.physical_address !== w.pa) begin
						$error("physical_address: expected %0h, actual %0h", w.pa,
							rsp.physical_address);
						mismatch_count++;
					end
					if (rsp.frame_index !== w.frame) begin
						$error("frame_index: expected %0d, actual %0d", w.frame, rsp.frame_index);
						mismatch_count++;
					end
					if (rsp.status !== w.status) begin
						$error("status: expected %0d, actual %0d", w.status, rsp.status);
						mismatch_count++;
					end
					if (rsp.new_second_level !== w.new_l2) begin
						$error("new_second_level: expected %0d, actual %0d", w.new_l2,
							rsp.new_second_level);
						mismatch_count++;
					end
				end
			end
			if (stall_gap > 0) begin
				stall_gap--;
				rsp.ready <= 1'b0;
			end else if (addr_queue.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
				stall_gap = $urandom_range(0, 11);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		va_item_t           item;
		logic [PN_BITS-1:0] page;
		logic [PN_BITS-1:0] visited[$];
		req.valid = 1'b0;
		req.virtual_address = '0;
		rsp.ready = 1'b0;

		foreach (DIRECTED_VA[i]) begin
			item.va = DIRECTED_VA[i];
			item.hold = 1'b0;
			addr_queue.push_back(item);
			visited.push_back(DIRECTED_VA[i][VA_BITS-1:PAGE_BITS]);
		end

		// Early on, new random pages avoid the upper four level-1 entries so that memory fills up
		// first and later accesses create level-2 tables while memory is full.
		for (int i = 0; i < WALK_COUNT; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				page = visited[$urandom_range(0, visited.size() - 1)];
			end else if (i < 110) begin
				page = {L1_BITS'($urandom_range(0, NUM_L1 - 5)), L2_BITS'($urandom())};
			end else begin
				page = PN_BITS'($urandom());
			end
			visited.push_back(page);
			item.va = {page, PAGE_BITS'($urandom())};
			item.hold = (i == 0 || i == WALK_COUNT / 2);
			addr_queue.push_back(item);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (addr_queue.size() != 0 || req.valid)
			@(posedge clk);
		while (expected_walks.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && expected_walks.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
